@@ rtl/core/hnorm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnorm_pkg
// shared widths, constants and types for the heightfield normal stencil
// ----------------------------------------------------------------------------
package hnorm_pkg;

    localparam int COORD_W = 7;
    localparam int RES_W   = 7;
    localparam int Q_DEPTH = 4;

    localparam logic [RES_W-1:0] RES_RESET = 7'd64;

    // which extra results a queued word produces after its middle-row point
    typedef struct packed {
        logic has_bottom;
        logic has_corner;
    } hnorm_kind_t;

endpackage

@@ rtl/core/hnorm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnorm_front
// accepts height words, tracks grid position, keeps the three line stores
// and forms the stencil differences for the back end
// ----------------------------------------------------------------------------
module hnorm_front
    import hnorm_pkg::*;
#(
    parameter int MAX_RES     = 64,
    parameter int HEIGHT_BITS = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [RES_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [HEIGHT_BITS-1:0]   height,
    input  logic                     q_ready,
    output logic                     q_push,
    output hnorm_kind_t              q_kind,
    output logic [COORD_W-1:0]       q_col,
    output logic [COORD_W-1:0]       q_row,
    output logic [HEIGHT_BITS:0]     q_nx,
    output logic [HEIGHT_BITS:0]     q_nz,
    output logic [HEIGHT_BITS:0]     q_bx
);

    localparam int DEPTH = MAX_RES + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = (AW > RES_W) ? AW : RES_W;
    localparam int HB    = HEIGHT_BITS;

    logic [RES_W-1:0] res_reg;
    logic [AW-1:0]    col_reg, col_next;
    logic [AW-1:0]    row_reg, row_next;
    logic [1:0]       rot_reg, rot_next;

    logic [EW-1:0]    res_ext;
    logic [AW-1:0]    last_idx;
    logic             accept;
    logic             at_col_end, at_row_end;
    logic [1:0]       mid_sel, up_sel;
    logic [AW-1:0]    addr_next, addr_prev;

    logic [HB-1:0]    rd_a_reg [3];
    logic [HB-1:0]    rd_b_reg [3];
    logic [HB-1:0]    prev1_reg, prev2_reg;

    logic             s1_valid_reg, s1_valid_next;
    logic [AW-1:0]    s1_col_reg, s1_row_reg;
    hnorm_kind_t      s1_kind_reg;
    logic             s1_has_res_reg, s1_edge_reg, s1_top_reg, s1_bx_en_reg;
    logic [HB-1:0]    s1_h_reg, s1_h2_reg;
    logic [1:0]       s1_mid_sel_reg, s1_up_sel_reg;

    logic [HB-1:0]    mid_l, mid_r, up_h;

    // effective resolution, clamped to 1..MAX_RES
    always_comb
    begin
        res_ext = EW'(res_reg);
        if (res_reg == '0)
            last_idx = AW'(1);
        else if (res_ext > EW'(MAX_RES))
            last_idx = AW'(MAX_RES);
        else
            last_idx = res_ext[AW-1:0];
    end

    assign at_col_end = (col_reg == last_idx);
    assign at_row_end = (row_reg == last_idx);

    assign in_stall = s1_valid_reg && s1_has_res_reg && !q_ready;
    assign accept   = in_valid && !in_stall;

    // line store roles rotate at each row end except the last row of the frame
    always_comb
    begin
        case (rot_reg)
            2'd0:
            begin
                mid_sel = 2'd2;
                up_sel  = 2'd1;
            end
            2'd1:
            begin
                mid_sel = 2'd0;
                up_sel  = 2'd2;
            end
            2'd2:
            begin
                mid_sel = 2'd1;
                up_sel  = 2'd0;
            end
            default:
            begin
                mid_sel = 2'd2;
                up_sel  = 2'd1;
            end
        endcase
    end

    assign addr_next = at_col_end ? col_reg : col_reg + AW'(1);
    assign addr_prev = (col_reg == '0) ? col_reg : col_reg - AW'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        rot_next = rot_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (at_col_end)
            begin
                col_next = '0;
                if (at_row_end)
                    row_next = '0;
                else
                begin
                    row_next = row_reg + AW'(1);
                    rot_next = (rot_reg == 2'd2) ? 2'd0 : rot_reg + 2'd1;
                end
            end
            else
                col_next = col_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= RES_RESET;
            col_reg <= '0;
            row_reg <= '0;
            rot_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                res_reg <= cfg_wdata;
            col_reg <= col_next;
            row_reg <= row_next;
            rot_reg <= rot_next;
        end
    end

    // three line stores, one write and two registered reads each
    for (genvar g = 0; g < 3; g++)
    begin : g_line
        logic [HB-1:0] line_mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                if (rot_reg == 2'(g))
                    line_mem[col_reg] <= height;
                rd_a_reg[g] <= line_mem[(mid_sel == 2'(g)) ? addr_next : col_reg];
                rd_b_reg[g] <= line_mem[addr_prev];
            end
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (in_stall ? s1_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev1_reg                  <= height;
            prev2_reg                  <= prev1_reg;
            s1_h_reg                   <= height;
            s1_h2_reg                  <= prev2_reg;
            s1_col_reg                 <= col_reg;
            s1_row_reg                 <= row_reg;
            s1_mid_sel_reg             <= mid_sel;
            s1_up_sel_reg              <= up_sel;
            s1_has_res_reg             <= (row_reg != '0);
            s1_top_reg                 <= (row_reg == AW'(1));
            s1_edge_reg                <= (col_reg == '0) || at_col_end;
            s1_bx_en_reg               <= (col_reg > AW'(1));
            s1_kind_reg.has_bottom     <= at_row_end && (col_reg != '0);
            s1_kind_reg.has_corner     <= at_row_end && at_col_end;
        end
    end

    assign mid_l = rd_b_reg[s1_mid_sel_reg];
    assign mid_r = rd_a_reg[s1_mid_sel_reg];
    assign up_h  = rd_a_reg[s1_up_sel_reg];

    assign q_push = s1_valid_reg && s1_has_res_reg && q_ready;
    assign q_kind = s1_kind_reg;
    assign q_col  = COORD_W'(s1_col_reg);
    assign q_row  = COORD_W'(s1_row_reg);
    assign q_nx   = s1_edge_reg ? '0 :
                    {mid_l[HB-1], mid_l} - {mid_r[HB-1], mid_r};
    assign q_nz   = s1_top_reg ? '0 :
                    {up_h[HB-1], up_h} - {s1_h_reg[HB-1], s1_h_reg};
    assign q_bx   = s1_bx_en_reg ?
                    {s1_h2_reg[HB-1], s1_h2_reg} - {s1_h_reg[HB-1], s1_h_reg} : '0;

endmodule

@@ rtl/core/hnorm_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnorm_queue
// short fifo between front and back so each side stalls on its own
// ----------------------------------------------------------------------------
module hnorm_queue
    import hnorm_pkg::*;
#(
    parameter int WIDTH = 93
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             ready,
    output logic             valid,
    output logic [WIDTH-1:0] rdata,
    input  logic             pop
);

    localparam int PW = $clog2(Q_DEPTH);

    logic [WIDTH-1:0] slot_reg [Q_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    assign ready = (count_reg != (PW+1)'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (PW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

@@ rtl/core/hnorm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnorm_back
// expands each queued word into its one to three normals and drives the
// registered output channel
// ----------------------------------------------------------------------------
module hnorm_back
    import hnorm_pkg::*;
#(
    parameter int NORMAL_BITS = 25
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  hnorm_kind_t                   q_kind,
    input  logic [COORD_W-1:0]            q_col,
    input  logic [COORD_W-1:0]            q_row,
    input  logic [NORMAL_BITS-1:0]        q_nx,
    input  logic [NORMAL_BITS-1:0]        q_nz,
    input  logic [NORMAL_BITS-1:0]        q_bx,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [COORD_W-1:0]            column,
    output logic [COORD_W-1:0]            row,
    output logic signed [NORMAL_BITS-1:0] normal_x,
    output logic signed [NORMAL_BITS-1:0] normal_z,
    output logic                          last_of_run
);

    localparam logic [1:0] PH_MID    = 2'd0;
    localparam logic [1:0] PH_BOTTOM = 2'd1;
    localparam logic [1:0] PH_CORNER = 2'd2;

    logic [1:0]             phase_reg, phase_next, phase_step;
    logic                   out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]     column_reg, row_reg;
    logic [NORMAL_BITS-1:0] nx_reg, nz_reg;
    logic                   last_reg;

    logic                   load, fire, sel_last;
    logic [COORD_W-1:0]     sel_col, sel_row;
    logic [NORMAL_BITS-1:0] sel_x, sel_z;

    assign load = !out_valid_reg || !out_stall;
    assign fire = load && q_valid;

    always_comb
    begin
        unique case (phase_reg)
            PH_BOTTOM:
            begin
                sel_col    = q_col - COORD_W'(1);
                sel_row    = q_row;
                sel_x      = q_bx;
                sel_z      = '0;
                sel_last   = !q_kind.has_corner;
                phase_step = PH_CORNER;
            end
            PH_CORNER:
            begin
                sel_col    = q_col;
                sel_row    = q_row;
                sel_x      = '0;
                sel_z      = '0;
                sel_last   = 1'b1;
                phase_step = PH_MID;
            end
            default:
            begin
                sel_col    = q_col;
                sel_row    = q_row - COORD_W'(1);
                sel_x      = q_nx;
                sel_z      = q_nz;
                sel_last   = !q_kind.has_bottom;
                phase_step = PH_BOTTOM;
            end
        endcase
    end

    assign q_pop          = fire && sel_last;
    assign phase_next     = fire ? (sel_last ? PH_MID : phase_step) : phase_reg;
    assign out_valid_next = load ? q_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            column_reg <= sel_col;
            row_reg    <= sel_row;
            nx_reg     <= sel_x;
            nz_reg     <= sel_z;
            last_reg   <= sel_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign column      = column_reg;
    assign row         = row_reg;
    assign normal_x    = nx_reg;
    assign normal_z    = nz_reg;
    assign last_of_run = last_reg;

endmodule

@@ rtl/core/heightfield_normal_stencil.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_normal_stencil
// streams a raster heightfield and emits a central-difference normal for
// every grid point
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in        in   in_valid / in_stall  height
//  out       out  out_valid / out_stall column, row, normal_x, normal_z,
//                                      last_of_run
//  cfg       in   cfg_we               cfg_wdata (res)
//
//  one height word per cycle while in_stall is low; row 0 words give no
//  result, other rows one, bottom-row words after the first two and the
//  last word three; the back end sends one result per cycle while out_stall
//  is low, so the input can stall on the bottom row
//  reset: res is 64, position at the grid origin, no words in flight
//  a four-word queue parts the line-store front end from the output side
// ----------------------------------------------------------------------------
module heightfield_normal_stencil
    import hnorm_pkg::*;
#(
    parameter int MAX_RES     = 64,
    parameter int HEIGHT_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [RES_W-1:0]              cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [HEIGHT_BITS-1:0] height,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [COORD_W-1:0]            column,
    output logic [COORD_W-1:0]            row,
    output logic signed [HEIGHT_BITS:0]   normal_x,
    output logic signed [HEIGHT_BITS:0]   normal_z,
    output logic                          last_of_run
);

    localparam int NB = HEIGHT_BITS + 1;
    localparam int QW = $bits(hnorm_kind_t) + 2 * COORD_W + 3 * NB;

    logic               q_ready, q_push, q_valid, q_pop;
    logic [QW-1:0]      q_wdata, q_rdata;

    hnorm_kind_t        f_kind, b_kind;
    logic [COORD_W-1:0] f_col, f_row, b_col, b_row;
    logic [NB-1:0]      f_nx, f_nz, f_bx, b_nx, b_nz, b_bx;

    hnorm_front #(
        .MAX_RES     (MAX_RES),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .height    (height),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_kind    (f_kind),
        .q_col     (f_col),
        .q_row     (f_row),
        .q_nx      (f_nx),
        .q_nz      (f_nz),
        .q_bx      (f_bx)
    );

    assign q_wdata = {f_kind, f_col, f_row, f_nx, f_nz, f_bx};

    hnorm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .ready (q_ready),
        .valid (q_valid),
        .rdata (q_rdata),
        .pop   (q_pop)
    );

    assign {b_kind, b_col, b_row, b_nx, b_nz, b_bx} = q_rdata;

    hnorm_back #(
        .NORMAL_BITS (NB)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_kind      (b_kind),
        .q_col       (b_col),
        .q_row       (b_row),
        .q_nx        (b_nx),
        .q_nz        (b_nz),
        .q_bx        (b_bx),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .column      (column),
        .row         (row),
        .normal_x    (normal_x),
        .normal_z    (normal_z),
        .last_of_run (last_of_run)
    );

endmodule

@@ rtl/core/hnorm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnorm_checker
// port-level checks on the normal output channel
// ----------------------------------------------------------------------------
module hnorm_checker
    import hnorm_pkg::*;
#(
    parameter int NORMAL_BITS = 25
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [COORD_W-1:0]            column,
    input logic [COORD_W-1:0]            row,
    input logic signed [NORMAL_BITS-1:0] normal_x,
    input logic signed [NORMAL_BITS-1:0] normal_z,
    input logic                          last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(column) && $stable(row) &&
            $stable(normal_x) && $stable(normal_z) && $stable(last_of_run))
        else $error("output word changed while stalled");

    // top row has no vertical neighbour pair
    a_top_row_z: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (row == '0) |-> (normal_z == '0))
        else $error("nonzero z on top row");

    // left column has no horizontal neighbour pair
    a_left_col_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (column == '0) |-> (normal_x == '0))
        else $error("nonzero x on left column");

endmodule

bind heightfield_normal_stencil hnorm_checker #(
    .NORMAL_BITS (HEIGHT_BITS + 1)
) u_hnorm_checker (.*);

@@ test/heightfield_normal_stencil_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_normal_stencil_tb
// streams height grids through the stencil and checks every normal word
// against a line-store predictor kept in the bench, with random sender
// bursts and receiver stalls; covers the reset resolution, clamped and
// zero resolutions, mid-frame restarts, frame wrap and extreme heights
// ----------------------------------------------------------------------------
module heightfield_normal_stencil_tb;
    import hnorm_pkg::*;

    localparam int MAX_RES      = 64;
    localparam int HEIGHT_W     = 24;
    localparam int NORMAL_W     = HEIGHT_W + 1;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 12;
    localparam int RANDOM_ITEMS = 200;

    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 24'sh7FFFFF;
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 24'sh800000;

    typedef struct {
        logic [COORD_W-1:0]         column;
        logic [COORD_W-1:0]         row;
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_z;
        logic                       last;
    } normal_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [RES_W-1:0]           cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [HEIGHT_W-1:0] height = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [COORD_W-1:0]         column;
    logic [COORD_W-1:0]         row;
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_z;
    logic                       last_of_run;

    // predictor state
    logic signed [HEIGHT_W-1:0] line_above [0:MAX_RES];
    logic signed [HEIGHT_W-1:0] line_mid   [0:MAX_RES];
    logic signed [HEIGHT_W-1:0] line_cur   [0:MAX_RES];
    logic [RES_W-1:0]           res_reg = RES_RESET;
    int unsigned                pos_col = 0;
    int unsigned                pos_row = 0;
    normal_t                    pending_normals [$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_mode  = 0;
    int unsigned mode_left   = 0;

    heightfield_normal_stencil #(
        .MAX_RES     (MAX_RES),
        .HEIGHT_BITS (HEIGHT_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .height      (height),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .column      (column),
        .row         (row),
        .normal_x    (normal_x),
        .normal_z    (normal_z),
        .last_of_run (last_of_run)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("heightfield_normal_stencil regression: fail");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2: out_stall <= (cycle_count % 5) < 2;
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_normals.size() == 0)
            begin
                $error("unexpected word column %0d row %0d", column, row);
                error_count++;
            end
            else
            begin
                want = pending_normals.pop_front();
                if (column !== want.column)
                begin
                    $error("column expected %0d got %0d", want.column, column);
                    error_count++;
                end
                if (row !== want.row)
                begin
                    $error("row expected %0d got %0d", want.row, row);
                    error_count++;
                end
                if (normal_x !== want.normal_x)
                begin
                    $error("normal_x expected %0d got %0d", want.normal_x, normal_x);
                    error_count++;
                end
                if (normal_z !== want.normal_z)
                begin
                    $error("normal_z expected %0d got %0d", want.normal_z, normal_z);
                    error_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run expected %0d got %0d", want.last, last_of_run);
                    error_count++;
                end
            end
        end
    end

    function automatic int unsigned grid_res();
        if (res_reg == 0)
            return 1;
        if (res_reg > MAX_RES)
            return MAX_RES;
        return 32'(res_reg);
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] rand_height();
        case ($urandom_range(0, 9))
            0: return HEIGHT_MAX;
            1: return HEIGHT_MIN;
            2: return HEIGHT_W'(int'($urandom_range(0, 511)) - 256);
            default: return HEIGHT_W'($urandom);
        endcase
    endfunction

    task automatic predict_normals(input logic signed [HEIGHT_W-1:0] h);
        int unsigned n;
        int unsigned c;
        int unsigned r;
        normal_t     pt;
        normal_t     run [$];
        n = grid_res();
        c = (pos_col > n) ? n : pos_col;
        r = (pos_row > n) ? n : pos_row;
        line_cur[c] = h;
        if (r >= 1)
        begin
            pt.column   = COORD_W'(c);
            pt.row      = COORD_W'(r - 1);
            pt.normal_x = '0;
            pt.normal_z = '0;
            pt.last     = 1'b0;
            if (c != 0 && c != n)
                pt.normal_x = NORMAL_W'(line_mid[c-1]) - NORMAL_W'(line_mid[c+1]);
            if (r >= 2)
                pt.normal_z = NORMAL_W'(line_above[c]) - NORMAL_W'(h);
            run.push_back(pt);
            if (r == n)
            begin
                // bottom row point to the left, then the far corner
                if (c >= 1)
                begin
                    pt.column   = COORD_W'(c - 1);
                    pt.row      = COORD_W'(n);
                    pt.normal_x = '0;
                    pt.normal_z = '0;
                    if (c >= 2)
                        pt.normal_x = NORMAL_W'(line_cur[c-2]) - NORMAL_W'(h);
                    run.push_back(pt);
                end
                if (c == n)
                begin
                    pt.column   = COORD_W'(n);
                    pt.row      = COORD_W'(n);
                    pt.normal_x = '0;
                    pt.normal_z = '0;
                    run.push_back(pt);
                end
            end
            run[run.size()-1].last = 1'b1;
            foreach (run[i])
                pending_normals.push_back(run[i]);
        end
        if (c >= n)
        begin
            pos_col = 0;
            if (r >= n)
            begin
                pos_row = 0;
            end
            else
            begin
                line_above = line_mid;
                line_mid   = line_cur;
                pos_row    = r + 1;
            end
        end
        else
        begin
            pos_col = c + 1;
            pos_row = r;
        end
    endtask

    task automatic send_height(input logic signed [HEIGHT_W-1:0] h);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        height   <= h;
        do
            @(posedge clk);
        while (in_stall);
        predict_normals(h);
    endtask

    task automatic drain_normals();
        while (pending_normals.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_res(input logic [RES_W-1:0] value);
        in_valid <= 1'b0;
        drain_normals();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        res_reg = value;
        pos_col = 0;
        pos_row = 0;
    endtask

    task automatic test_reset_resolution();
        repeat (2 * (MAX_RES + 1) + 5) send_height(rand_height());
    endtask

    task automatic test_small_grids();
        write_res(7'd1);
        send_height(HEIGHT_MAX);
        send_height(HEIGHT_MIN);
        send_height(HEIGHT_MIN);
        send_height(HEIGHT_MAX);
        // zero resolution behaves as one
        write_res(7'd0);
        send_height(HEIGHT_MIN);
        send_height(HEIGHT_MAX);
        send_height(HEIGHT_MAX);
        send_height(HEIGHT_MIN);
        // full-scale differences in every direction
        write_res(7'd2);
        send_height(HEIGHT_MAX);
        send_height('0);
        send_height(HEIGHT_MIN);
        send_height(HEIGHT_MIN);
        send_height(HEIGHT_MAX);
        send_height(HEIGHT_MAX);
        send_height(HEIGHT_MIN);
        send_height(HEIGHT_MIN);
        send_height(HEIGHT_MAX);
        // stop part way into a frame so the next resolution write restarts it
        write_res(7'd2);
        repeat (5) send_height(rand_height());
    endtask

    task automatic test_res_clamp();
        write_res(7'd127);
        repeat (MAX_RES + 6) send_height(rand_height());
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned pick;
        int unsigned span;
        int unsigned count;
        int unsigned cap;
        logic [RES_W-1:0] value;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                value = '0;
            else if (pick == 1)
                value = RES_W'($urandom_range(65, 127));
            else if (pick < 10)
                value = RES_W'($urandom_range(1, 4));
            else if (pick < 18)
                value = RES_W'($urandom_range(5, 10));
            else
                value = RES_W'($urandom_range(11, 20));
            write_res(value);
            span = (value == 0) ? 2 : ((value > MAX_RES) ? MAX_RES + 1 : value + 1);
            cap  = (span * span < 80) ? span * span : 80;
            if (value > MAX_RES || $urandom_range(0, 4) == 0)
                count = $urandom_range(1, cap);
            else
                count = span * span * $urandom_range(1, 3);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            repeat (count) send_height(rand_height());
            sent += count;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_resolution();
        test_small_grids();
        test_res_clamp();
        test_random_frames();
        in_valid <= 1'b0;
        drain_normals();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("heightfield_normal_stencil regression: pass");
        else
            $display("heightfield_normal_stencil regression: fail");
        $finish;
    end

endmodule
